// ----- design/panel_grid_pixel_remap_top_defines.svh -----
// Assertion macros used by the checker file of the panel grid remapper.
`ifndef PANEL_GRID_PIXEL_REMAP_TOP_DEFINES_SVH
`define PANEL_GRID_PIXEL_REMAP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PGR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PGR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pgr_pkg.sv -----
// Shared constants, types and register codes of the panel grid remapper.
package pgr_pkg;

  localparam int MAX_PANELS = 16;
  localparam int IDX_W      = $clog2(MAX_PANELS);

  localparam int COORD_W  = 12;
  localparam int CANVAS_W = 11;
  localparam int PANEL_W  = 7;
  localparam int CHAIN_W  = 5;
  localparam int TABLE_W  = 64;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam int MX_W = 11;
  localparam int MY_W = 9;

  localparam int ENTRY_W = 8;
  localparam int ROT_W   = 2;
  localparam int ORDER_W = 4;
  localparam int PAR_W   = 2;

  // Long division: DIV_STAGES stages of DIV_STEPS restoring steps cover DIV_W bits.
  localparam int DIV_W      = 12;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;
  localparam int PROD_W     = 2 * DIV_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_TUSER_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISPLAY_WIDTH  = 3'd0,
    CFG_DISPLAY_HEIGHT = 3'd1,
    CFG_TILE_WIDTH     = 3'd2,
    CFG_TILE_HEIGHT    = 3'd3,
    CFG_CHAIN_LEN      = 3'd4,
    CFG_PANEL_TABLE_LO = 3'd5,
    CFG_PANEL_TABLE_HI = 3'd6
  } cfg_reg_e;

  typedef enum logic [ROT_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef struct packed {
    logic [CANVAS_W-1:0] display_width;
    logic [CANVAS_W-1:0] display_height;
    logic [PANEL_W-1:0]  tile_w;
    logic [PANEL_W-1:0]  tile_h;
    logic [CHAIN_W-1:0]  chain_len;
    logic [TABLE_W-1:0]  panel_table_lo;
    logic [TABLE_W-1:0]  panel_table_hi;
  } pgr_cfg_t;

  // One division lane: nq shifts dividend bits out at the top and quotient bits in.
  typedef struct packed {
    logic [DIV_W-1:0]   nq;
    logic [PANEL_W-1:0] rem;
  } pgr_lane_t;

  typedef struct packed {
    logic      off;
    pgr_lane_t x;
    pgr_lane_t y;
    pgr_lane_t c;
  } pgr_div_t;

  typedef struct packed {
    logic               off;
    logic [PROD_W-1:0]  prod;
    logic [DIV_W-1:0]   col;
    logic [PANEL_W-1:0] rx;
    logic [PANEL_W-1:0] ry;
  } pgr_prod_t;

  typedef struct packed {
    logic               ok;
    logic [PANEL_W-1:0] px;
    logic [PANEL_W-1:0] py;
    logic [ORDER_W-1:0] order;
    logic [PAR_W-1:0]   par;
  } pgr_place_t;

endpackage

// ----- design/pgr_div_stage.sv -----
// One pipeline stage of the three-lane restoring divider.
module pgr_div_stage import pgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pgr_cfg_t cfg_i,
  input  logic     in_valid_i,
  input  pgr_div_t in_data_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output pgr_div_t out_data_o,
  input  logic     out_ready_i
);

  logic     valid_q;
  pgr_div_t data_q;
  pgr_div_t data_d;

  function automatic pgr_lane_t div_step(pgr_lane_t l, logic [PANEL_W-1:0] d);
    logic [PANEL_W:0] t;
    logic [PANEL_W:0] diff;
    pgr_lane_t        r;
    t      = {l.rem, l.nq[DIV_W-1]};
    diff   = t - {1'b0, d};
    r.nq   = {l.nq[DIV_W-2:0], 1'b0};
    r.rem  = t[PANEL_W-1:0];
    if (t >= {1'b0, d}) begin
      r.nq[0] = 1'b1;
      r.rem   = diff[PANEL_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < DIV_STEPS; s++) begin
      data_d.x = div_step(data_d.x, cfg_i.tile_w);
      data_d.y = div_step(data_d.y, cfg_i.tile_h);
      data_d.c = div_step(data_d.c, cfg_i.tile_w);
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- design/pgr_index.sv -----
// Panel index stage: multiplies the panel column count by the panel row.
module pgr_index import pgr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  pgr_div_t  in_data_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output pgr_prod_t out_data_o,
  input  logic      out_ready_i
);

  logic      valid_q;
  pgr_prod_t data_q;
  pgr_prod_t data_d;

  always_comb begin
    data_d.off  = in_data_i.off;
    data_d.prod = PROD_W'(in_data_i.c.nq) * PROD_W'(in_data_i.y.nq);
    data_d.col  = in_data_i.x.nq;
    data_d.rx   = in_data_i.x.rem;
    data_d.ry   = in_data_i.y.rem;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- design/pgr_map.sv -----
// Table lookup and in-panel rotation stage.
module pgr_map import pgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pgr_cfg_t   cfg_i,
  input  logic       in_valid_i,
  input  pgr_prod_t  in_data_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output pgr_place_t out_data_o,
  input  logic       out_ready_i
);

  logic                 valid_q;
  pgr_place_t           data_q;
  pgr_place_t           data_d;
  logic [SUM_W-1:0]     idx_sum;
  logic                 in_table;
  logic [2*TABLE_W-1:0] table_all;
  logic [ENTRY_W-1:0]   entry;
  rot_e                 rot;
  logic                 quarter_bad;
  logic [PANEL_W-1:0]   flip_x;
  logic [PANEL_W-1:0]   flip_y;

  always_comb begin
    idx_sum   = {1'b0, in_data_i.prod} + SUM_W'(in_data_i.col);
    in_table  = idx_sum < SUM_W'(MAX_PANELS);
    table_all = {cfg_i.panel_table_hi, cfg_i.panel_table_lo};
    entry     = table_all[{idx_sum[IDX_W-1:0], 3'b000} +: ENTRY_W];
    rot       = rot_e'(entry[ROT_W-1:0]);
    // Quarter turns only make sense on square panels.
    quarter_bad = (rot == ROT_90 || rot == ROT_270) &&
                  (cfg_i.tile_w != cfg_i.tile_h);
    flip_x = cfg_i.tile_w - PANEL_W'(1) - in_data_i.rx;
    flip_y = cfg_i.tile_h - PANEL_W'(1) - in_data_i.ry;

    data_d.ok    = !in_data_i.off && in_table && !quarter_bad;
    data_d.order = entry[ROT_W +: ORDER_W];
    data_d.par   = entry[ROT_W+ORDER_W +: PAR_W];
    case (rot)
      ROT_0: begin
        data_d.px = in_data_i.rx;
        data_d.py = in_data_i.ry;
      end
      ROT_90: begin
        data_d.px = flip_y;
        data_d.py = in_data_i.rx;
      end
      ROT_180: begin
        data_d.px = flip_x;
        data_d.py = flip_y;
      end
      ROT_270: begin
        data_d.px = in_data_i.ry;
        data_d.py = flip_x;
      end
      default: begin
        data_d.px = in_data_i.rx;
        data_d.py = in_data_i.ry;
      end
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

// ----- design/pgr_place.sv -----
// Chain and parallel offset stage; its register drives the result stream.
module pgr_place import pgr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pgr_cfg_t         cfg_i,
  input  logic             in_valid_i,
  input  pgr_place_t       in_data_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [MX_W-1:0]  mat_col_o,
  output logic [MY_W-1:0]  mat_row_o,
  output logic             mapped_o,
  input  logic             out_ready_i
);

  logic              valid_q;
  logic [MX_W-1:0]   mx_q;
  logic [MX_W-1:0]   mx_d;
  logic [MY_W-1:0]   my_q;
  logic [MY_W-1:0]   my_d;
  logic              ok_q;
  logic [MX_W-1:0]   chain_pos;
  logic [MX_W-1:0]   chain_off;
  logic [MY_W-1:0]   par_off;

  always_comb begin
    // The chain starts at its far end, so the order counts backwards.
    chain_pos = MX_W'(cfg_i.chain_len) - MX_W'(1) - MX_W'(in_data_i.order);
    chain_off = chain_pos * MX_W'(cfg_i.tile_w);
    par_off   = MY_W'(in_data_i.par) * MY_W'(cfg_i.tile_h);
    if (in_data_i.ok) begin
      mx_d = MX_W'(in_data_i.px) + chain_off;
      my_d = MY_W'(in_data_i.py) + par_off;
    end else begin
      mx_d = '1;
      my_d = '1;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign mat_col_o   = mx_q;
  assign mat_row_o   = my_q;
  assign mapped_o    = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mx_q <= mx_d;
      my_q <= my_d;
      ok_q <= in_data_i.ok;
    end
  end

endmodule

// ----- design/panel_grid_pixel_remap_top.sv -----
// Top level of the panel grid remapper: canvas point in, chained matrix point out.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: canvas_col [11:0], canvas_row [23:12]
//  m_axis    out        tdata: mat_col [10:0], mat_row [19:11]; tuser: mapped
//  cfg       in         write enable, register index, 64-bit write data
//
// One request per clock while m_axis takes results; the pipeline has four divider
// stages of three restoring steps each, then index multiply, table lookup with
// rotation, and the offset stage whose register drives m_axis.
// Reset is asynchronous and active low; it restores the default geometry.
// Each stage holds while its successor is full, so bubbles are squeezed out and
// new requests are taken while a finished result waits on m_axis.
module panel_grid_pixel_remap_top import pgr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // canvas_col [11:0], canvas_row [23:12]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // mat_col [10:0], mat_row [19:11], zero [23:20]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // mapped [0]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  pgr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_width  <= CANVAS_W'(32);
      cfg_q.display_height <= CANVAS_W'(32);
      cfg_q.tile_w         <= PANEL_W'(32);
      cfg_q.tile_h         <= PANEL_W'(32);
      cfg_q.chain_len      <= CHAIN_W'(1);
      cfg_q.panel_table_lo <= '0;
      cfg_q.panel_table_hi <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_DISPLAY_WIDTH:  cfg_q.display_width  <= cfg_wdata_i[CANVAS_W-1:0];
        CFG_DISPLAY_HEIGHT: cfg_q.display_height <= cfg_wdata_i[CANVAS_W-1:0];
        CFG_TILE_WIDTH:     cfg_q.tile_w         <= cfg_wdata_i[PANEL_W-1:0];
        CFG_TILE_HEIGHT:    cfg_q.tile_h         <= cfg_wdata_i[PANEL_W-1:0];
        CFG_CHAIN_LEN:      cfg_q.chain_len      <= cfg_wdata_i[CHAIN_W-1:0];
        CFG_PANEL_TABLE_LO: cfg_q.panel_table_lo <= cfg_wdata_i[TABLE_W-1:0];
        CFG_PANEL_TABLE_HI: cfg_q.panel_table_hi <= cfg_wdata_i[TABLE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COORD_W-1:0] vx;
  logic [COORD_W-1:0] vy;
  pgr_div_t           div_in;

  assign vx = s_axis_tdata_i[COORD_W-1:0];
  assign vy = s_axis_tdata_i[2*COORD_W-1:COORD_W];

  always_comb begin
    // Negative, past the canvas edge, or a zero panel size: no mapping.
    div_in.off = vx[COORD_W-1] || vy[COORD_W-1] ||
                 (vx[CANVAS_W-1:0] >= cfg_q.display_width) ||
                 (vy[CANVAS_W-1:0] >= cfg_q.display_height) ||
                 (cfg_q.tile_w == '0) || (cfg_q.tile_h == '0);
    div_in.x.nq  = DIV_W'(vx[CANVAS_W-1:0]);
    div_in.x.rem = '0;
    div_in.y.nq  = DIV_W'(vy[CANVAS_W-1:0]);
    div_in.y.rem = '0;
    div_in.c.nq  = DIV_W'(cfg_q.display_width);
    div_in.c.rem = '0;
  end

  logic       div_valid [DIV_STAGES+1];
  logic       div_ready [DIV_STAGES+1];
  pgr_div_t   div_data  [DIV_STAGES+1];

  assign div_valid[0]    = s_axis_tvalid_i;
  assign div_data[0]     = div_in;
  assign s_axis_tready_o = div_ready[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pgr_div_stage u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .in_valid_i  (div_valid[g]),
      .in_data_i   (div_data[g]),
      .in_ready_o  (div_ready[g]),
      .out_valid_o (div_valid[g+1]),
      .out_data_o  (div_data[g+1]),
      .out_ready_i (div_ready[g+1])
    );
  end

  logic       prod_valid;
  logic       prod_ready;
  pgr_prod_t  prod_data;
  logic       place_valid;
  logic       place_ready;
  pgr_place_t place_data;

  pgr_index u_index (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid[DIV_STAGES]),
    .in_data_i   (div_data[DIV_STAGES]),
    .in_ready_o  (div_ready[DIV_STAGES]),
    .out_valid_o (prod_valid),
    .out_data_o  (prod_data),
    .out_ready_i (prod_ready)
  );

  pgr_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (prod_valid),
    .in_data_i   (prod_data),
    .in_ready_o  (prod_ready),
    .out_valid_o (place_valid),
    .out_data_o  (place_data),
    .out_ready_i (place_ready)
  );

  logic [MX_W-1:0] mat_col;
  logic [MY_W-1:0] mat_row;
  logic            mapped;

  pgr_place u_place (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (place_valid),
    .in_data_i   (place_data),
    .in_ready_o  (place_ready),
    .out_valid_o (m_axis_tvalid_o),
    .mat_col_o   (mat_col),
    .mat_row_o   (mat_row),
    .mapped_o    (mapped),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W-MX_W-MY_W)'(0), mat_row, mat_col};
  assign m_axis_tuser_o = OUT_TUSER_W'(mapped);

endmodule

// ----- design/pgr_checker.sv -----
// Port-level checks of the panel grid remapper, bound to its top level.
`include "panel_grid_pixel_remap_top_defines.svh"

module pgr_checker import pgr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_TUSER_W-1:0] m_axis_tuser_o
);

  // A result that is not mapped carries minus one in both coordinates.
  `PGR_ASSERT_NOW(a_unmapped_minus_one, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o[MX_W+MY_W-1:0] == '1, "unmapped result is not minus one")

  // The input can only be held off by a pipeline whose output is waiting.
  `PGR_ASSERT_NOW(a_stall_needs_output, clk_i, rst_ni, !s_axis_tready_o, m_axis_tvalid_o, "input stalled with no result pending")

  `PGR_ASSERT_NOW(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[OUT_TDATA_W-1:MX_W+MY_W] == '0, "result padding bits are not zero")

  `PGR_ASSERT_NEXT(a_result_held, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

endmodule

bind panel_grid_pixel_remap_top pgr_checker u_pgr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- tb/testbench.sv -----
// Self-checking stream testbench for the panel grid remapper.
module testbench;
  import pgr_pkg::*;

  typedef struct packed {
    logic [MX_W-1:0] mx;
    logic [MY_W-1:0] my;
    logic            mapped;
  } point_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  pgr_cfg_t                geom;
  logic [IN_TDATA_W-1:0]   point_requests[$];
  point_t                  expected_points[$];
  point_t                  head_point;
  int                      mismatches = 0;
  int                      gap_pct = 0;
  int                      stall_pct = 0;
  int                      gap_left = 0;
  int                      stall_left = 0;

  panel_grid_pixel_remap_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Where a canvas point should land in the chained matrix under the current geometry.
  function automatic point_t remap_point(logic signed [COORD_W-1:0] vx,
                                         logic signed [COORD_W-1:0] vy);
    int x, y, pw, ph, dw, dh, cols, idx, px, py, t, order, par;
    logic [ENTRY_W-1:0] entry;
    rot_e rot;
    point_t res;
    res.mx = '1;
    res.my = '1;
    res.mapped = 1'b0;
    x = vx;
    y = vy;
    pw = geom.tile_w;
    ph = geom.tile_h;
    dw = geom.display_width;
    dh = geom.display_height;
    if (x < 0 || y < 0 || x >= dw || y >= dh || pw == 0 || ph == 0) return res;
    cols = dw / pw;
    idx = cols * (y / ph) + x / pw;
    if (idx >= MAX_PANELS) return res;
    if (idx < 8) entry = geom.panel_table_lo[ENTRY_W*idx +: ENTRY_W];
    else entry = geom.panel_table_hi[ENTRY_W*(idx-8) +: ENTRY_W];
    rot = rot_e'(entry[ROT_W-1:0]);
    order = entry[ROT_W +: ORDER_W];
    par = entry[ROT_W+ORDER_W +: PAR_W];
    px = x % pw;
    py = y % ph;
    // Quarter turns only make sense on square panels.
    if ((rot == ROT_90 || rot == ROT_270) && pw != ph) return res;
    case (rot)
      ROT_90: begin
        t = px;
        px = (ph - 1) - py;
        py = t;
      end
      ROT_180: begin
        px = (pw - 1) - px;
        py = (ph - 1) - py;
      end
      ROT_270: begin
        t = py;
        py = (pw - 1) - px;
        px = t;
      end
      default: ;
    endcase
    // The chain starts at its far end, so the order counts backward.
    px += (int'(geom.chain_len) - 1 - order) * pw;
    py += par * ph;
    res.mx = px[MX_W-1:0];
    res.my = py[MY_W-1:0];
    res.mapped = 1'b1;
    return res;
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_geometry_reg(cfg_reg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_DISPLAY_WIDTH:  geom.display_width = value[CANVAS_W-1:0];
      CFG_DISPLAY_HEIGHT: geom.display_height = value[CANVAS_W-1:0];
      CFG_TILE_WIDTH:     geom.tile_w = value[PANEL_W-1:0];
      CFG_TILE_HEIGHT:    geom.tile_h = value[PANEL_W-1:0];
      CFG_CHAIN_LEN:      geom.chain_len = value[CHAIN_W-1:0];
      CFG_PANEL_TABLE_LO: geom.panel_table_lo = value;
      CFG_PANEL_TABLE_HI: geom.panel_table_hi = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(int x, int y);
    point_requests.push_back({y[COORD_W-1:0], x[COORD_W-1:0]});
  endtask

  task automatic drain();
    // Sampled at the falling edge so the driver and monitor updates have settled.
    while (point_requests.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
      @(negedge clk_i);
    // Pipeline is seven deep; then wait on with no traffic so it settles.
    repeat (10) @(posedge clk_i);
  endtask

  // Request driver: predicts each request as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_points.push_back(remap_point(s_axis_tdata[COORD_W-1:0],
                                              s_axis_tdata[2*COORD_W-1:COORD_W]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (point_requests.size() > 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(1, 18) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (point_requests.size() > 0) begin
          s_axis_tdata <= point_requests.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_points.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          head_point = expected_points.pop_front();
          if (m_axis_tdata[MX_W-1:0] !== head_point.mx)
            report($sformatf("mat_col got %0d expected %0d",
                             $signed(m_axis_tdata[MX_W-1:0]), $signed(head_point.mx)));
          if (m_axis_tdata[MX_W +: MY_W] !== head_point.my)
            report($sformatf("mat_row got %0d expected %0d",
                             $signed(m_axis_tdata[MX_W +: MY_W]), $signed(head_point.my)));
          if (m_axis_tuser[0] !== head_point.mapped)
            report($sformatf("mapped got %b expected %b", m_axis_tuser[0],
                             head_point.mapped));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("panel_grid_pixel_remap_top test failed");
    $finish;
  end

  initial begin
    int pw, ph, dw, dh, x, y, sel;
    logic [CFG_W-1:0] lo, hi, chain;
    geom.display_width = 32;
    geom.display_height = 32;
    geom.tile_w = 32;
    geom.tile_h = 32;
    geom.chain_len = 1;
    geom.panel_table_lo = '0;
    geom.panel_table_hi = '0;
    gap_pct = 20;
    stall_pct = 20;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: one panel covers the canvas; corners and off-canvas points.
    queue_point(0, 0);
    queue_point(31, 31);
    queue_point(31, 0);
    queue_point(-1, 5);
    queue_point(5, -1);
    queue_point(32, 0);
    queue_point(0, 32);
    queue_point(-2048, -2048);
    queue_point(2047, 2047);
    drain();

    // Two by two square panels, one of each rotation.
    write_geometry_reg(CFG_DISPLAY_WIDTH, 64);
    write_geometry_reg(CFG_DISPLAY_HEIGHT, 64);
    write_geometry_reg(CFG_TILE_WIDTH, 32);
    write_geometry_reg(CFG_TILE_HEIGHT, 32);
    write_geometry_reg(CFG_CHAIN_LEN, 2);
    write_geometry_reg(CFG_PANEL_TABLE_LO, 64'h0000_0000_4742_0500);
    write_geometry_reg(CFG_PANEL_TABLE_HI, '1);
    queue_point(3, 5);
    queue_point(40, 7);
    queue_point(10, 50);
    queue_point(60, 60);
    drain();

    // Wide panels: quarter turns are refused, and a far order wraps negative.
    write_geometry_reg(CFG_TILE_HEIGHT, 16);
    write_geometry_reg(CFG_DISPLAY_HEIGHT, 32);
    write_geometry_reg(CFG_CHAIN_LEN, 1);
    write_geometry_reg(CFG_PANEL_TABLE_LO, 64'h0000_0000_FCCA_3F01);
    queue_point(1, 1);
    queue_point(33, 2);
    queue_point(5, 20);
    queue_point(40, 20);
    drain();

    // Partial last column, and tiles beyond the sixteen table entries.
    write_geometry_reg(CFG_DISPLAY_WIDTH, 44);
    write_geometry_reg(CFG_DISPLAY_HEIGHT, 64);
    write_geometry_reg(CFG_TILE_WIDTH, 8);
    write_geometry_reg(CFG_TILE_HEIGHT, 8);
    write_geometry_reg(CFG_CHAIN_LEN, 5);
    write_geometry_reg(CFG_PANEL_TABLE_LO, {$urandom, $urandom});
    write_geometry_reg(CFG_PANEL_TABLE_HI, {$urandom, $urandom});
    queue_point(42, 0);
    queue_point(42, 9);
    queue_point(0, 24);
    queue_point(43, 63);
    drain();

    // A zero panel width maps nothing.
    write_geometry_reg(CFG_TILE_WIDTH, 0);
    queue_point(0, 0);
    queue_point(5, 5);
    drain();

    for (int k = 0; k < 13; k++) begin
      pw = $urandom_range(1, 64);
      ph = ($urandom_range(0, 1) != 0) ? pw : $urandom_range(1, 64);
      dw = pw * $urandom_range(1, 4);
      dh = ph * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) dw += $urandom_range(0, pw - 1);
      if ($urandom_range(0, 3) == 0) dh += $urandom_range(0, ph - 1);
      chain = $urandom_range(1, 16);
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (k == 0) begin
        pw = 64;
        ph = 64;
        dw = 1024;
        dh = 1024;
        chain = 16;
        lo = '1;
        hi = '1;
      end else if (k == 1) begin
        pw = 1;
        ph = 1;
        dw = 1;
        dh = 1;
        chain = 1;
        lo = '0;
        hi = '0;
      end
      write_geometry_reg(CFG_DISPLAY_WIDTH, dw);
      write_geometry_reg(CFG_DISPLAY_HEIGHT, dh);
      write_geometry_reg(CFG_TILE_WIDTH, pw);
      write_geometry_reg(CFG_TILE_HEIGHT, ph);
      write_geometry_reg(CFG_CHAIN_LEN, chain);
      write_geometry_reg(CFG_PANEL_TABLE_LO, lo);
      write_geometry_reg(CFG_PANEL_TABLE_HI, hi);
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 15; stall_pct = 15; end
        default: begin gap_pct = 50; stall_pct = 40; end
      endcase
      // The closing phase runs at full rate on both sides.
      if (k == 12) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      for (int n = 0; n < 148; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          x = $urandom_range(0, dw - 1);
          y = $urandom_range(0, dh - 1);
        end else if (sel == 7) begin
          x = dw - 1 + $urandom_range(0, 2);
          y = dh - 2 + $urandom_range(0, 2);
        end else begin
          x = $urandom;
          y = $urandom;
        end
        queue_point(x, y);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("panel_grid_pixel_remap_top test passed");
    end else begin
      $display("panel_grid_pixel_remap_top test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/pgr_pkg.sv
design/pgr_div_stage.sv
design/pgr_index.sv
design/pgr_map.sv
design/pgr_place.sv
design/panel_grid_pixel_remap_top.sv
design/pgr_checker.sv
tb/testbench.sv
